// ----- rtl/pose_slew_and_frame_transform_defines.svh -----
// Assertion macros for the pose slew and frame transform block.
// Included by the modules that carry concurrent assertions.
`ifndef POSE_SLEW_AND_FRAME_TRANSFORM_DEFINES_SVH
`define POSE_SLEW_AND_FRAME_TRANSFORM_DEFINES_SVH
`ifndef SYNTH
`define PSFT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PSFT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PSFT_ASSERT(label, clk, rst_n, prop)
`define PSFT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/psft_pkg.sv -----
// Package for the pose slew and frame transform block.
// Holds widths, register indexes, operation codes, sine constants, shared structs and helper functions.
`default_nettype none
package psft_pkg;
    localparam int AngleBits = 16;
    localparam int SineDepth = 256;
    localparam int SineIdxBits = $clog2(SineDepth);
    localparam int LenBits = 24;
    localparam int RateBits = 20;
    localparam int DtBits = 16;
    localparam int AccBits = 51;

    localparam logic [1:0] REG_HEADING_RATE = 2'd0;
    localparam logic [1:0] REG_TILT_RATE = 2'd1;
    localparam logic [1:0] REG_HEIGHT_RATE = 2'd2;
    localparam logic [1:0] REG_LEG_OFFSET = 2'd3;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    localparam logic [16:0] SinA = 17'd51472;
    localparam logic [16:0] SinB = 17'd21024;
    localparam logic [16:0] SinC = 17'd2320;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_TICK,
        CMD_ROT1,
        CMD_ROT2,
        CMD_ROT3,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic [1:0] phase;
    } ctrl_t;

    typedef struct packed {
        logic is_xform;
    } status_t;

    // Sine of a 16-bit phase in Q16 turns, Q15 result.
    function automatic logic signed [17:0] sin_phase(input logic [15:0] p);
        logic signed [17:0] t;
        logic neg;
        logic [16:0] z;
        logic [33:0] zz;
        logic [16:0] z2;
        logic [33:0] pc;
        logic [17:0] inner;
        logic [35:0] pm;
        logic [17:0] mid;
        logic [35:0] pr;
        logic [17:0] r;
        t = 18'(signed'(p));
        if (t > 18'sd16384)
            t = 18'sd32768 - t;
        else if (t < -18'sd16384)
            t = -18'sd32768 - t;
        neg = t[17];
        z = neg ? 17'(-t) << 1 : 17'(t) << 1;
        zz = z * z;
        z2 = 17'(zz >> 15);
        pc = z2 * SinC;
        inner = 18'(SinB) - 18'(pc >> 15);
        pm = z2 * inner;
        mid = 18'(SinA) - 18'(pm >> 15);
        pr = z * mid;
        r = 18'(pr >> 15);
        return neg ? -signed'(r) : signed'(r);
    endfunction

    function automatic logic [15:0] angle_phase(input logic [AngleBits-1:0] a);
        logic [AngleBits+SineIdxBits:0] prod;
        logic [SineIdxBits-1:0] k;
        prod = ((AngleBits+SineIdxBits+1)'(a) << SineIdxBits)
            + ((AngleBits+SineIdxBits+1)'(1) << (AngleBits - 1));
        k = SineIdxBits'(prod >> AngleBits);
        return 16'((32'(k) << 16) >> SineIdxBits);
    endfunction

    function automatic logic signed [LenBits-1:0] sat24(input logic signed [AccBits-1:0] v);
        if (v > AccBits'(signed'(24'h7FFFFF)))
            return 24'sh7FFFFF;
        else if (v < AccBits'(signed'(24'sh800000)))
            return 24'sh800000;
        return LenBits'(v);
    endfunction
endpackage
`default_nettype wire

// ----- rtl/psft_if.sv -----
// Valid/ready channel interfaces for the pose slew and frame transform block.
// Field widths are written out here and do not use psft_pkg.
`default_nettype none
interface psft_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic [15:0] time_step;
    logic signed [15:0] goal_heading;
    logic signed [15:0] goal_tilt_azimuth;
    logic signed [15:0] goal_tilt_polar;
    logic signed [23:0] goal_height;
    logic signed [23:0] foot_x;
    logic signed [23:0] foot_y;
    logic signed [23:0] foot_z;
    logic signed [23:0] body_x;
    logic signed [23:0] body_y;
    modport source (output valid, operation, time_step, goal_heading, goal_tilt_azimuth,
        goal_tilt_polar, goal_height, foot_x, foot_y, foot_z, body_x, body_y, input ready);
    modport sink (input valid, operation, time_step, goal_heading, goal_tilt_azimuth,
        goal_tilt_polar, goal_height, foot_x, foot_y, foot_z, body_x, body_y, output ready);
endinterface

interface psft_out_if;
    logic valid;
    logic ready;
    logic signed [23:0] leg_x;
    logic signed [23:0] leg_y;
    logic signed [23:0] leg_z;
    logic signed [15:0] now_heading;
    logic signed [15:0] now_tilt_azimuth;
    logic signed [15:0] now_tilt_polar;
    logic signed [23:0] now_height;
    modport source (output valid, leg_x, leg_y, leg_z, now_heading, now_tilt_azimuth,
        now_tilt_polar, now_height, input ready);
    modport sink (input valid, leg_x, leg_y, leg_z, now_heading, now_tilt_azimuth,
        now_tilt_polar, now_height, output ready);
endinterface

interface psft_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/psft_ctrl.sv -----
// Controller state machine: sequences a tick or three rotation passes.
// Depends on psft_pkg and the assertion macro header.
`default_nettype none
`include "pose_slew_and_frame_transform_defines.svh"
module psft_ctrl (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input wire logic out_ready,
    input wire psft_pkg::status_t status,
    output psft_pkg::ctrl_t ctrl
);
    typedef enum logic [2:0] {S_IDLE, S_TICK, S_ROT1, S_ROT2, S_ROT3, S_FIN, S_OUT} state_t;
    state_t state_reg;
    logic [1:0] phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    phase_reg <= '0;
                    if (in_valid)
                        state_reg <= S_TICK;
                end
                S_TICK:
                begin
                    phase_reg <= '0;
                    state_reg <= status.is_xform ? S_ROT1 : S_FIN;
                end
                S_ROT1, S_ROT2, S_ROT3:
                begin
                    if (phase_reg == 2'd2)
                    begin
                        phase_reg <= '0;
                        state_reg <= (state_reg == S_ROT1) ? S_ROT2 :
                            (state_reg == S_ROT2) ? S_ROT3 : S_FIN;
                    end
                    else
                        phase_reg <= phase_reg + 2'd1;
                end
                S_FIN: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
        ctrl.phase = phase_reg;
        case (state_reg)
            S_IDLE: ctrl.cmd = in_valid ? psft_pkg::CMD_LOAD : psft_pkg::CMD_NONE;
            S_TICK: ctrl.cmd = status.is_xform ? psft_pkg::CMD_NONE : psft_pkg::CMD_TICK;
            S_ROT1: ctrl.cmd = psft_pkg::CMD_ROT1;
            S_ROT2: ctrl.cmd = psft_pkg::CMD_ROT2;
            S_ROT3: ctrl.cmd = psft_pkg::CMD_ROT3;
            S_FIN: ctrl.cmd = psft_pkg::CMD_FINISH;
            default: ctrl.cmd = psft_pkg::CMD_NONE;
        endcase
    end

    `PSFT_ASSERT(a_no_overlap, clk, rst_n, !(in_ready && out_valid))
    `PSFT_ASSERT(a_out_holds, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
    `PSFT_ASSERT(a_accept_starts, clk, rst_n, (in_valid && in_ready) |=> (state_reg == S_TICK))
endmodule
`default_nettype wire

// ----- rtl/psft_datapath.sv -----
// Datapath: pose registers, slew limiting, rotation multipliers, output register.
// Depends on psft_pkg for widths, sine function and command codes.
`default_nettype none
module psft_datapath (
    input wire logic clk,
    input wire logic rst_n,
    input wire psft_pkg::ctrl_t ctrl,
    output psft_pkg::status_t status,
    input wire logic op_in,
    input wire logic [15:0] dt_in,
    input wire logic [15:0] gh_in,
    input wire logic [15:0] ga_in,
    input wire logic [15:0] gp_in,
    input wire logic signed [23:0] gz_in,
    input wire logic signed [23:0] fx_in,
    input wire logic signed [23:0] fy_in,
    input wire logic signed [23:0] fz_in,
    input wire logic signed [23:0] bx_in,
    input wire logic signed [23:0] by_in,
    input wire logic cfg_we,
    input wire logic [1:0] cfg_idx,
    input wire logic [31:0] cfg_data,
    output logic signed [23:0] leg_x,
    output logic signed [23:0] leg_y,
    output logic signed [23:0] leg_z,
    output logic [15:0] heading,
    output logic [15:0] azimuth,
    output logic [15:0] polar,
    output logic signed [23:0] height
);
    localparam int AB = psft_pkg::AccBits;
    logic [19:0] hrate_reg, trate_reg, zrate_reg;
    logic signed [23:0] offset_reg;
    logic [15:0] heading_reg, azimuth_reg, polar_reg;
    logic signed [23:0] height_reg;
    logic op_reg;
    logic [15:0] dt_reg, gh_reg, ga_reg, gp_reg;
    logic signed [23:0] gz_reg;
    logic signed [AB-1:0] u_reg, v_reg, w_reg;
    logic signed [AB-1:0] pa_reg, pb_reg;
    logic signed [17:0] s_reg, c_reg;
    logic signed [23:0] lx_reg, ly_reg, lz_reg;

    function automatic logic [15:0] slew(input logic [15:0] cur, input logic [15:0] goal,
        input logic [19:0] rate, input logic [15:0] dt);
        logic [35:0] prod;
        logic [19:0] step;
        logic signed [20:0] d;
        prod = rate * dt;
        step = prod[35:16];
        d = 21'(signed'(goal - cur));
        if (goal - cur == 16'h8000)
            d = 21'sd32768;
        if (d > signed'({1'b0, step}))
            d = signed'({1'b0, step});
        else if (d < -signed'({1'b0, step}))
            d = -signed'({1'b0, step});
        return cur + d[15:0];
    endfunction

    logic [35:0] zprod;
    logic signed [25:0] zd, zstep, znew;
    logic [15:0] rot_angle;
    logic [15:0] rot_phase;
    logic signed [AB-1:0] ra, rb, mul_a, mul_b;
    logic signed [AB-1:0] sum_u, sum_v;
    logic signed [17:0] sin_tab [psft_pkg::SineDepth];
    logic [psft_pkg::SineIdxBits-1:0] sin_idx, cos_idx;

    // The phase only takes table-step values, so sine is a constant table.
    for (genvar gi = 0; gi < psft_pkg::SineDepth; gi++)
    begin : g_sine
        assign sin_tab[gi] = psft_pkg::sin_phase(16'(gi << (16 - psft_pkg::SineIdxBits)));
    end

    always_comb
    begin
        zprod = zrate_reg * dt_reg;
        zstep = 26'(zprod[35:16]);
        zd = 26'(gz_reg) - 26'(height_reg);
        if (zd > zstep)
            zd = zstep;
        else if (zd < -zstep)
            zd = -zstep;
        znew = 26'(height_reg) + zd;
        case (ctrl.cmd)
            psft_pkg::CMD_ROT1: rot_angle = 16'(0) - (heading_reg + azimuth_reg);
            psft_pkg::CMD_ROT2: rot_angle = 16'(0) - polar_reg;
            default: rot_angle = azimuth_reg;
        endcase
        rot_phase = psft_pkg::angle_phase(rot_angle);
        sin_idx = rot_phase[15 -: psft_pkg::SineIdxBits];
        cos_idx = sin_idx + psft_pkg::SineIdxBits'(psft_pkg::SineDepth / 4);
        // Rotation about Y works on x and z; the others on x and y.
        ra = u_reg;
        rb = (ctrl.cmd == psft_pkg::CMD_ROT2) ? w_reg : v_reg;
        mul_a = (ctrl.phase == 2'd1) ? AB'(c_reg) * ra : AB'(c_reg) * rb;
        mul_b = (ctrl.phase == 2'd1) ? AB'(s_reg) * rb : AB'(s_reg) * ra;
        sum_u = (ctrl.cmd == psft_pkg::CMD_ROT2) ? pa_reg + pb_reg : pa_reg - pb_reg;
        sum_v = (ctrl.cmd == psft_pkg::CMD_ROT2) ? mul_a - mul_b : mul_b + mul_a;
        status.is_xform = (op_reg == psft_pkg::OP_XFORM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hrate_reg <= 20'd16384;
            trate_reg <= 20'd16384;
            zrate_reg <= 20'd2560;
            offset_reg <= '0;
            heading_reg <= '0;
            azimuth_reg <= '0;
            polar_reg <= '0;
            height_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    psft_pkg::REG_HEADING_RATE: hrate_reg <= cfg_data[19:0];
                    psft_pkg::REG_TILT_RATE: trate_reg <= cfg_data[19:0];
                    psft_pkg::REG_HEIGHT_RATE: zrate_reg <= cfg_data[19:0];
                    psft_pkg::REG_LEG_OFFSET: offset_reg <= cfg_data[23:0];
                    default: offset_reg <= offset_reg;
                endcase
            end
            if (ctrl.cmd == psft_pkg::CMD_TICK)
            begin
                heading_reg <= slew(heading_reg, gh_reg, hrate_reg, dt_reg);
                azimuth_reg <= slew(azimuth_reg, ga_reg, trate_reg, dt_reg);
                polar_reg <= slew(polar_reg, gp_reg, trate_reg, dt_reg);
                height_reg <= psft_pkg::sat24(AB'(znew));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.cmd)
            psft_pkg::CMD_LOAD:
            begin
                op_reg <= op_in;
                dt_reg <= dt_in;
                gh_reg <= gh_in;
                ga_reg <= ga_in;
                gp_reg <= gp_in;
                gz_reg <= gz_in;
                u_reg <= AB'(fx_in) - AB'(bx_in);
                v_reg <= AB'(fy_in) - AB'(by_in);
                w_reg <= AB'(fz_in);
                lx_reg <= '0;
                ly_reg <= '0;
                lz_reg <= '0;
            end
            psft_pkg::CMD_TICK: w_reg <= w_reg;
            psft_pkg::CMD_ROT1, psft_pkg::CMD_ROT2, psft_pkg::CMD_ROT3:
            begin
                if (ctrl.cmd == psft_pkg::CMD_ROT1 && ctrl.phase == 2'd0)
                    w_reg <= w_reg - AB'(height_reg);
                case (ctrl.phase)
                    2'd0:
                    begin
                        s_reg <= sin_tab[sin_idx];
                        c_reg <= sin_tab[cos_idx];
                    end
                    2'd1:
                    begin
                        pa_reg <= mul_a;
                        pb_reg <= mul_b;
                    end
                    default:
                    begin
                        u_reg <= (sum_u + AB'(16384)) >>> 15;
                        if (ctrl.cmd == psft_pkg::CMD_ROT2)
                            w_reg <= (sum_v + AB'(16384)) >>> 15;
                        else
                            v_reg <= (sum_v + AB'(16384)) >>> 15;
                    end
                endcase
            end
            psft_pkg::CMD_FINISH:
            begin
                if (op_reg == psft_pkg::OP_XFORM)
                begin
                    lx_reg <= psft_pkg::sat24(u_reg);
                    ly_reg <= psft_pkg::sat24(v_reg);
                    lz_reg <= psft_pkg::sat24(w_reg - AB'(offset_reg));
                end
            end
            default: op_reg <= op_reg;
        endcase
    end

    assign leg_x = lx_reg;
    assign leg_y = ly_reg;
    assign leg_z = lz_reg;
    assign heading = heading_reg;
    assign azimuth = azimuth_reg;
    assign polar = polar_reg;
    assign height = height_reg;
endmodule
`default_nettype wire

// ----- rtl/pose_slew_and_frame_transform.sv -----
// A pose tick passes the load, tick, finish and output states; a foot transform also passes
// three rotation passes. One item at a time: no new input is taken until the result is taken.
// The three rotations share one pair of multipliers; each looks up sine, multiplies, then rounds.
// Reset (rst_n, asynchronous, active low) clears the pose to zero and loads
// the default rate limits and a zero leg plane offset.
`default_nettype none
module pose_slew_and_frame_transform (
    input wire logic clk,
    input wire logic rst_n,
    psft_in_if.sink in_ch,
    psft_out_if.source out_ch,
    psft_cfg_if.sink cfg
);
    psft_pkg::ctrl_t ctrl;
    psft_pkg::status_t status;
    logic [15:0] h, a, p;

    assign cfg.ready = 1'b1;

    psft_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .status(status), .ctrl(ctrl)
    );

    psft_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .status(status),
        .op_in(in_ch.operation), .dt_in(in_ch.time_step),
        .gh_in(in_ch.goal_heading), .ga_in(in_ch.goal_tilt_azimuth),
        .gp_in(in_ch.goal_tilt_polar), .gz_in(in_ch.goal_height),
        .fx_in(in_ch.foot_x), .fy_in(in_ch.foot_y), .fz_in(in_ch.foot_z),
        .bx_in(in_ch.body_x), .by_in(in_ch.body_y),
        .cfg_we(cfg.valid), .cfg_idx(cfg.index), .cfg_data(cfg.data),
        .leg_x(out_ch.leg_x), .leg_y(out_ch.leg_y), .leg_z(out_ch.leg_z),
        .heading(h), .azimuth(a), .polar(p), .height(out_ch.now_height)
    );

    assign out_ch.now_heading = h;
    assign out_ch.now_tilt_azimuth = a;
    assign out_ch.now_tilt_polar = p;
endmodule
`default_nettype wire

// ----- test/tb_psft_pkg.sv -----
`timescale 1ns / 100ps
// Pose predictor and result checker for the pose slew and frame transform testbench.
// Depends on psft_pkg for widths and operation codes.
package tb_psft_pkg;
    import psft_pkg::*;

    typedef struct {
        logic op;
        logic [15:0] dt;
        logic [15:0] gh;
        logic [15:0] ga;
        logic [15:0] gp;
        logic [23:0] gz;
        logic [23:0] fx;
        logic [23:0] fy;
        logic [23:0] fz;
        logic [23:0] bx;
        logic [23:0] by;
    } pose_item_t;

    typedef struct {
        logic [23:0] lx;
        logic [23:0] ly;
        logic [23:0] lz;
        logic [15:0] hd;
        logic [15:0] az;
        logic [15:0] pl;
        logic [23:0] ht;
    } pose_result_t;

    class pose_scoreboard;
        longint unsigned rate_heading;
        longint unsigned rate_tilt;
        longint unsigned rate_height;
        longint offset;
        longint unsigned heading;
        longint unsigned azimuth;
        longint unsigned polar;
        longint height;
        pose_result_t pending[$];
        int errors;
        int checked;

        function new();
            rate_heading = 16384;
            rate_tilt = 16384;
            rate_height = 2560;
            offset = 0;
            heading = 0;
            azimuth = 0;
            polar = 0;
            height = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == REG_HEADING_RATE)
                rate_heading = data[19:0];
            else if (idx == REG_TILT_RATE)
                rate_tilt = data[19:0];
            else if (idx == REG_HEIGHT_RATE)
                rate_height = data[19:0];
            else if (idx == REG_LEG_OFFSET)
                offset = longint'(signed'(data[23:0]));
        endfunction

        static function longint clip24(longint v);
            if (v > 8388607)
                return 8388607;
            if (v < -8388608)
                return -8388608;
            return v;
        endfunction

        static function longint poly_sine(longint unsigned ph);
            longint t;
            longint z;
            longint z2;
            longint inner;
            longint mid;
            longint r;
            logic neg;
            t = longint'(ph & 16'hFFFF);
            if (t >= 32768)
                t -= 65536;
            if (t > 16384)
                t = 32768 - t;
            else if (t < -16384)
                t = -32768 - t;
            neg = t < 0;
            z = (neg ? -t : t) * 2;
            z2 = (z * z) >>> 15;
            inner = 21024 - ((z2 * 2320) >>> 15);
            mid = 51472 - ((z2 * inner) >>> 15);
            r = (z * mid) >>> 15;
            return neg ? -r : r;
        endfunction

        static function longint round15(longint v);
            return (v + 16384) >>> 15;
        endfunction

        static function void rotate(longint unsigned ang, inout longint u, inout longint v,
                input logic about_y);
            longint unsigned k;
            longint unsigned p;
            longint s;
            longint c;
            longint a;
            longint b;
            k = (((ang & 16'hFFFF) * 256) + 32768) >> 16;
            k = k % 256;
            p = ((k << 16) / 256) & 16'hFFFF;
            s = poly_sine(p);
            c = poly_sine((p + 16384) & 16'hFFFF);
            a = u;
            b = v;
            if (about_y)
            begin
                u = round15(c * a + s * b);
                v = round15(c * b - s * a);
            end
            else
            begin
                u = round15(c * a - s * b);
                v = round15(s * a + c * b);
            end
        endfunction

        static function longint unsigned slew(longint unsigned cur, logic [15:0] goal,
                longint unsigned rate, longint unsigned dt);
            longint d;
            longint lim;
            d = longint'((longint'(goal) - cur) & 16'hFFFF);
            lim = longint'((rate * dt) >> 16);
            if (d > 32768)
                d -= 65536;
            if (d > lim)
                d = lim;
            else if (d < -lim)
                d = -lim;
            return longint'(longint'(cur) + d) & 16'hFFFF;
        endfunction

        function void note_item(pose_item_t it);
            pose_result_t r;
            longint x;
            longint y;
            longint z;
            longint d;
            longint lim;
            r.lx = '0;
            r.ly = '0;
            r.lz = '0;
            if (it.op == OP_TICK)
            begin
                d = longint'(signed'(it.gz)) - height;
                lim = longint'((rate_height * it.dt) >> 16);
                heading = slew(heading, it.gh, rate_heading, it.dt);
                azimuth = slew(azimuth, it.ga, rate_tilt, it.dt);
                polar = slew(polar, it.gp, rate_tilt, it.dt);
                if (d > lim)
                    d = lim;
                else if (d < -lim)
                    d = -lim;
                height = clip24(height + d);
            end
            else
            begin
                x = longint'(signed'(it.fx)) - longint'(signed'(it.bx));
                y = longint'(signed'(it.fy)) - longint'(signed'(it.by));
                z = longint'(signed'(it.fz)) - height;
                rotate((0 - (heading + azimuth)) & 16'hFFFF, x, y, 1'b0);
                rotate((0 - polar) & 16'hFFFF, x, z, 1'b1);
                rotate(azimuth, x, y, 1'b0);
                z -= offset;
                r.lx = clip24(x);
                r.ly = clip24(y);
                r.lz = clip24(z);
            end
            r.hd = heading[15:0];
            r.az = azimuth[15:0];
            r.pl = polar[15:0];
            r.ht = height[23:0];
            pending.push_back(r);
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on result %0d: %s got %h expected %h", checked, what, got, want);
            errors++;
        endfunction

        function void check_result(pose_result_t got);
            pose_result_t e;
            if (pending.size() == 0)
            begin
                $display("result %0d arrived with nothing expected", checked);
                errors++;
                checked++;
                return;
            end
            e = pending.pop_front();
            if (got.lx !== e.lx) report("leg_x", got.lx, e.lx);
            if (got.ly !== e.ly) report("leg_y", got.ly, e.ly);
            if (got.lz !== e.lz) report("leg_z", got.lz, e.lz);
            if (got.hd !== e.hd) report("now_heading", got.hd, e.hd);
            if (got.az !== e.az) report("now_tilt_azimuth", got.az, e.az);
            if (got.pl !== e.pl) report("now_tilt_polar", got.pl, e.pl);
            if (got.ht !== e.ht) report("now_height", got.ht, e.ht);
            checked++;
        endfunction
    endclass
endpackage

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Top level testbench for pose_slew_and_frame_transform: directed and random ticks
// and foot transforms under random idling and stalls. Depends on psft_pkg, psft_if, tb_psft_pkg.
module tb_top;
    import psft_pkg::*;
    import tb_psft_pkg::*;

    logic clk;
    logic rst_n;
    int cycle;
    int ticks_sent;
    int xforms_sent;
    bit stall_long;
    bit stall_free;
    pose_scoreboard sb;

    psft_in_if in_ch();
    psft_out_if out_ch();
    psft_cfg_if cfg();

    pose_slew_and_frame_transform u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg(cfg.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle > 400000)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_TICK;
        in_ch.time_step = '0;
        in_ch.goal_heading = '0;
        in_ch.goal_tilt_azimuth = '0;
        in_ch.goal_tilt_polar = '0;
        in_ch.goal_height = '0;
        in_ch.foot_x = '0;
        in_ch.foot_y = '0;
        in_ch.foot_z = '0;
        in_ch.body_x = '0;
        in_ch.body_y = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_HEADING_RATE;
        cfg.data = '0;
        stall_long = 1'b0;
        stall_free = 1'b0;
    end

    // Receiver: checks each result taken and stalls on its own pattern, with a long hold-off or none when asked.
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
            sb.check_result('{out_ch.leg_x, out_ch.leg_y, out_ch.leg_z, out_ch.now_heading,
                out_ch.now_tilt_azimuth, out_ch.now_tilt_polar, out_ch.now_height});
        if (stall_long)
            out_ch.ready <= 1'b0;
        else if (stall_free)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= (cycle % 64 < 40) ? ($urandom_range(0, 3) != 0)
                : ($urandom_range(0, 2) == 0);
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.write_reg(idx, data);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_item(pose_item_t it);
        in_ch.valid <= 1'b1;
        in_ch.operation <= it.op;
        in_ch.time_step <= it.dt;
        in_ch.goal_heading <= it.gh;
        in_ch.goal_tilt_azimuth <= it.ga;
        in_ch.goal_tilt_polar <= it.gp;
        in_ch.goal_height <= it.gz;
        in_ch.foot_x <= it.fx;
        in_ch.foot_y <= it.fy;
        in_ch.foot_z <= it.fz;
        in_ch.body_x <= it.bx;
        in_ch.body_y <= it.by;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_item(it);
        if (it.op == OP_TICK)
            ticks_sent++;
        else
            xforms_sent++;
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        go_idle();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [23:0] rand24();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 2000)) - 24'd1000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic pose_item_t rand_item();
        pose_item_t it;
        it.op = ($urandom_range(0, 1) == 0) ? OP_TICK : OP_XFORM;
        it.dt = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF)
            : 16'($urandom);
        it.gh = 16'($urandom);
        it.ga = 16'($urandom);
        it.gp = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
        it.gz = rand24();
        it.fx = ($urandom_range(0, 3) == 0) ? rand24() : 24'($urandom_range(0, 80000)) - 24'd40000;
        it.fy = ($urandom_range(0, 3) == 0) ? rand24() : 24'($urandom_range(0, 80000)) - 24'd40000;
        it.fz = ($urandom_range(0, 3) == 0) ? rand24() : 24'($urandom_range(0, 80000)) - 24'd40000;
        it.bx = ($urandom_range(0, 3) == 0) ? rand24() : 24'($urandom_range(0, 20000)) - 24'd10000;
        it.by = ($urandom_range(0, 3) == 0) ? rand24() : 24'($urandom_range(0, 20000)) - 24'd10000;
        return it;
    endfunction

    function automatic pose_item_t tick_item(logic [15:0] dt, logic [15:0] gh, logic [15:0] ga,
            logic [15:0] gp, logic [23:0] gz);
        pose_item_t it;
        it = '{OP_TICK, dt, gh, ga, gp, gz, 24'h123456, 24'h654321, 24'h0F0F0F, 24'h7FFFFF,
            24'h800000};
        return it;
    endfunction

    function automatic pose_item_t xform_item(logic [23:0] fx, logic [23:0] fy, logic [23:0] fz,
            logic [23:0] bx, logic [23:0] by);
        pose_item_t it;
        it = '{OP_XFORM, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h4000, 24'h7FFFFF, fx, fy, fz, bx, by};
        return it;
    endfunction

    task automatic random_phase(int count);
        int burst;
        for (int i = 0; i < count; i++)
        begin
            send_item(rand_item());
            burst--;
            if (burst <= 0)
            begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0)
                begin
                    go_idle();
                    repeat ($urandom_range(1, 15)) @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        ticks_sent = 0;
        xforms_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        stall_free <= 1'b1;
        repeat (2) @(posedge clk);

        send_item(xform_item(24'h001000, 24'h000800, 24'h000400, 24'h000000, 24'h000000));
        send_item(tick_item(16'd0, 16'h4000, 16'h2000, 16'h1000, 24'h001000));
        send_item(tick_item(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 24'h7FFFFF));
        send_item(tick_item(16'hFFFF, 16'h7FFF, 16'hC000, 16'h0100, 24'h800000));
        send_item(xform_item(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF));
        send_item(xform_item(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000));
        drain();
        write_reg(REG_HEADING_RATE, 32'hFFFFF);
        write_reg(REG_TILT_RATE, 32'hFFFFF);
        write_reg(REG_HEIGHT_RATE, 32'hFFFFF);
        write_reg(REG_LEG_OFFSET, 32'h007FFFFF);
        send_item(tick_item(16'hFFFF, 16'h8000, 16'h4000, 16'hE000, 24'h7FFFFF));
        send_item(xform_item(24'h000500, 24'hFFFB00, 24'h000300, 24'h000100, 24'h000200));
        send_item(tick_item(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 24'h800000));
        send_item(tick_item(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 24'h800000));
        send_item(xform_item(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000));
        drain();
        write_reg(REG_HEADING_RATE, 32'h0);
        write_reg(REG_TILT_RATE, 32'h0);
        write_reg(REG_HEIGHT_RATE, 32'h0);
        write_reg(REG_LEG_OFFSET, 32'h00800000);
        send_item(tick_item(16'hFFFF, 16'h1234, 16'h5678, 16'h1357, 24'h000100));
        send_item(xform_item(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF));
        drain();
        stall_free <= 1'b0;

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_HEADING_RATE, 32'($urandom_range(0, 1048575)));
            write_reg(REG_TILT_RATE, (ph == 1) ? 32'hFFFFF : 32'($urandom_range(0, 200000)));
            write_reg(REG_HEIGHT_RATE, (ph == 2) ? 32'h0 : 32'($urandom_range(0, 1048575)));
            write_reg(REG_LEG_OFFSET, (ph == 3) ? 32'hFF800000 : 32'($urandom));
            if (ph == 2)
            begin
                fork
                    begin
                        stall_long <= 1'b1;
                        repeat (400) @(posedge clk);
                        stall_long <= 1'b0;
                    end
                    random_phase(60);
                join
            end
            random_phase(300);
            drain();
        end

        $display("covered %0d pose ticks and %0d foot transforms, %0d results checked",
            ticks_sent, xforms_sent, sb.checked);
        $display("register settings swept over both extremes, long output stall included");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    final
    begin
    end
endmodule
